@@ rtl/strem_pkg.sv @@
package strem_pkg;

  // Q0.16 unity
  localparam logic [16:0] Q16_ONE = 17'd65536;

  // quarter-wave sine polynomial coefficients (Q1.16)
  localparam logic [16:0] SIN_A = 17'd102944;
  localparam logic [16:0] SIN_B = 17'd42047;
  localparam logic [16:0] SIN_C = 17'd4640;

  // gain is Q0.32 in 0..2^32
  localparam int unsigned GAIN_W = 33;
  localparam logic [GAIN_W-1:0] GAIN_ONE = 33'h1_0000_0000;

  // LFO arithmetic width (Q0.16 values up to 1.0, sine terms up to ~1.57)
  localparam int unsigned LFO_W = 17;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned DEPTH_W    = 17;
  localparam int unsigned INC_W      = 24;
  localparam int unsigned WAVE_W     = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_DEPTH = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INC   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_WAVE  = 2'd2;

  localparam logic [WAVE_W-1:0] WAVE_SINE   = 2'd0;
  localparam logic [WAVE_W-1:0] WAVE_TRI    = 2'd1;
  localparam logic [WAVE_W-1:0] WAVE_SQUARE = 2'd2;

  localparam logic [DEPTH_W-1:0] DEPTH_RST = 17'd32768;
  localparam logic [INC_W-1:0]   INC_RST   = 24'd357914;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } strem_qstat_t;

endpackage

@@ rtl/stereo_tremolo_lfo_gain_core.sv @@
// Stereo tremolo: each request carries a left/right sample pair; both are
// scaled by gain = 1 - depth*u, where u is a unipolar LFO (sine, triangle or
// square) taken from a phase accumulator that starts at zero after reset and
// advances by phase_increment once per request. Products are floored. One
// result leaves for every request, in order, with tlast copied through.
// The front end accepts a request, evaluates the LFO and the gain on one
// shared 17x17 multiplier and pushes the work into a two-entry queue; the
// back end scales left then right on one sample-by-gain multiplier and parks
// the pair in an output register. A sine request holds the front end through
// accept, four polynomial steps, gain and push (which waits while the queue
// is full); triangle and square skip the polynomial steps. The back end pops,
// scales left, scales right and loads the output register once it is free.
// Configuration writes take effect at once and are meant for idle periods;
// register index 3 is ignored. No clearing pass after reset.
module stereo_tremolo_lfo_gain_core #(
  parameter int unsigned SAMPLE_BITS     = 24,
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [strem_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [strem_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // fields from bit 0: left_in, right_in, zero pad to bytes
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  input  logic                              in_tlast,   // block_end
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // fields from bit 0: left_out, right_out, zero pad to bytes
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] out_tdata,
  output logic                              out_tlast   // block_end_out
);

  localparam int unsigned QW = 2 * SAMPLE_BITS + 1 + strem_pkg::GAIN_W;

  // front -> queue -> back
  strem_pkg::strem_qstat_t q_stat;
  logic                    q_push;
  logic                    q_pop;
  logic [QW-1:0]           q_wdata;
  logic [QW-1:0]           q_rdata;

  logic [SAMPLE_BITS-1:0]  res_left;
  logic [SAMPLE_BITS-1:0]  res_right;

  strem_front #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .QW              (QW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_left   (in_tdata[SAMPLE_BITS-1:0]),
    .in_right  (in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .in_last   (in_tlast),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  // two entries let the front end start the next LFO while the back end scales
  strem_fifo #(
    .W     (QW),
    .DEPTH (2)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .stat      (q_stat)
  );

  strem_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .QW          (QW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .q_data    (q_rdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_left  (res_left),
    .out_right (res_right),
    .out_last  (out_tlast)
  );

  always_comb begin
    out_tdata = '0;
    out_tdata[SAMPLE_BITS-1:0]             = res_left;
    out_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS] = res_right;
  end

endmodule

@@ rtl/strem_fifo.sv @@
module strem_fifo #(
  parameter int unsigned W     = 83,
  parameter int unsigned DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [W-1:0]          push_data,
  input  logic                  pop,
  output logic [W-1:0]          pop_data,
  output strem_pkg::strem_qstat_t stat
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data   = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);

  // no overflow, no underflow, occupancy bounded, count steps up on a lone push
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < CW'(DEPTH) || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue occupancy out of range");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + CW'(1))
    else $error("queue count did not advance on push");

endmodule

@@ rtl/strem_front.sv @@
module strem_front #(
  parameter int unsigned SAMPLE_BITS     = 24,
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned SINE_TABLE_BITS = 10,
  parameter int unsigned QW              = 2 * SAMPLE_BITS + 1 + strem_pkg::GAIN_W
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [strem_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [strem_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [SAMPLE_BITS-1:0]            in_left,
  input  logic [SAMPLE_BITS-1:0]            in_right,
  input  logic                              in_last,
  input  strem_pkg::strem_qstat_t           q_stat,
  output logic                              q_push,
  output logic [QW-1:0]                     q_data
);

  localparam int unsigned LW  = strem_pkg::LFO_W;
  localparam int unsigned RW  = SINE_TABLE_BITS - 2;
  localparam int unsigned ZSH = 16 - RW;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_Z2   = 3'd1;
  localparam logic [2:0] F_T1   = 3'd2;
  localparam logic [2:0] F_T2   = 3'd3;
  localparam logic [2:0] F_S    = 3'd4;
  localparam logic [2:0] F_GAIN = 3'd5;
  localparam logic [2:0] F_PUSH = 3'd6;

  logic [2:0]                      state_r, state_nxt;
  logic [PHASE_BITS-1:0]           phase_r, phase_nxt;
  logic [strem_pkg::DEPTH_W-1:0]   depth_r;
  logic [strem_pkg::INC_W-1:0]     inc_r;
  logic [strem_pkg::WAVE_W-1:0]    wave_r;

  logic [SAMPLE_BITS-1:0]          left_r, right_r;
  logic                            last_r;
  logic [1:0]                      quad_r;
  logic [LW-1:0]                   z_r, z2_r, t_r, u_r;
  logic [strem_pkg::GAIN_W-1:0]    g_r;

  logic                            accept;
  logic [SINE_TABLE_BITS-1:0]      k;
  logic [RW-1:0]                   r;
  logic [LW-1:0]                   z_raw, z_new;
  logic [15:0]                     f;
  logic [LW-1:0]                   u_tri, u_sq;
  logic [LW-1:0]                   d_sat;
  logic [LW-1:0]                   mul_a, mul_b;
  logic [2*LW-1:0]                 prod;
  logic [LW:0]                     s_w;
  logic [LW-1:0]                   s_c;
  logic [LW:0]                     u_sum;

  assign in_ready = (state_r == F_IDLE);
  assign accept   = in_valid && in_ready;

  // LFO setup from the current phase
  assign k     = phase_r[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign r     = k[RW-1:0];
  assign z_raw = LW'(r) << ZSH;
  assign z_new = k[SINE_TABLE_BITS-2] ? (strem_pkg::Q16_ONE - z_raw) : z_raw;
  assign f     = phase_r[PHASE_BITS-1 -: 16];
  assign u_tri = f[15] ? LW'((LW+1)'(131072) - (LW+1)'({f, 1'b0})) : LW'({f, 1'b0});
  assign u_sq  = phase_r[PHASE_BITS-1] ? '0 : strem_pkg::Q16_ONE;
  assign d_sat = (depth_r > strem_pkg::Q16_ONE) ? strem_pkg::Q16_ONE : depth_r;

  // single shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      F_Z2: begin
        mul_a = z_r;
        mul_b = z_r;
      end
      F_T1: begin
        mul_a = z2_r;
        mul_b = strem_pkg::SIN_C;
      end
      F_T2: begin
        mul_a = z2_r;
        mul_b = t_r;
      end
      F_S: begin
        mul_a = z_r;
        mul_b = t_r;
      end
      F_GAIN: begin
        mul_a = d_sat;
        mul_b = u_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign s_w   = (LW+1)'(prod >> 16);
  assign s_c   = (s_w > (LW+1)'(strem_pkg::Q16_ONE)) ? strem_pkg::Q16_ONE : s_w[LW-1:0];
  assign u_sum = quad_r[1] ? ((LW+1)'(strem_pkg::Q16_ONE) - (LW+1)'(s_c))
                           : ((LW+1)'(strem_pkg::Q16_ONE) + (LW+1)'(s_c));

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    q_push    = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          phase_nxt = phase_r + PHASE_BITS'(inc_r);
          state_nxt = (wave_r == strem_pkg::WAVE_SINE) ? F_Z2 : F_GAIN;
        end
      end
      F_Z2:   state_nxt = F_T1;
      F_T1:   state_nxt = F_T2;
      F_T2:   state_nxt = F_S;
      F_S:    state_nxt = F_GAIN;
      F_GAIN: state_nxt = F_PUSH;
      F_PUSH: begin
        if (!q_stat.full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      phase_r <= '0;
      depth_r <= strem_pkg::DEPTH_RST;
      inc_r   <= strem_pkg::INC_RST;
      wave_r  <= strem_pkg::WAVE_SINE;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          strem_pkg::REG_DEPTH: depth_r <= cfg_wdata[strem_pkg::DEPTH_W-1:0];
          strem_pkg::REG_INC:   inc_r   <= cfg_wdata[strem_pkg::INC_W-1:0];
          strem_pkg::REG_WAVE:  wave_r  <= cfg_wdata[strem_pkg::WAVE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          left_r  <= in_left;
          right_r <= in_right;
          last_r  <= in_last;
          quad_r  <= k[SINE_TABLE_BITS-1 -: 2];
          z_r     <= z_new;
          u_r     <= (wave_r == strem_pkg::WAVE_TRI) ? u_tri : u_sq;
        end
      end
      F_Z2:   z2_r <= LW'(prod >> 16);
      F_T1:   t_r  <= strem_pkg::SIN_B - LW'(prod >> 16);
      F_T2:   t_r  <= strem_pkg::SIN_A - LW'(prod >> 16);
      F_S:    u_r  <= u_sum[LW:1];
      F_GAIN: g_r  <= strem_pkg::GAIN_ONE - strem_pkg::GAIN_W'(prod);
      default: ;
    endcase
  end

  assign q_data = {g_r, last_r, right_r, left_r};

endmodule

@@ rtl/strem_back.sv @@
module strem_back #(
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned QW          = 2 * SAMPLE_BITS + 1 + strem_pkg::GAIN_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  strem_pkg::strem_qstat_t q_stat,
  output logic                    q_pop,
  input  logic [QW-1:0]           q_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [SAMPLE_BITS-1:0]  out_left,
  output logic [SAMPLE_BITS-1:0]  out_right,
  output logic                    out_last
);

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned GW = strem_pkg::GAIN_W;

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_LEFT  = 2'd1;
  localparam logic [1:0] B_RIGHT = 2'd2;
  localparam logic [1:0] B_LOAD  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [SB-1:0]    left_r, right_r, lres_r, rres_r;
  logic             last_r;
  logic [GW-1:0]    g_r;
  logic             out_valid_r, out_valid_nxt;
  logic [SB-1:0]    out_left_r, out_right_r;
  logic             out_last_r;
  logic             load;

  logic [SB-1:0]    smp, mag, res;
  logic             neg;
  logic [SB+31:0]   prod;
  logic [SB+32:0]   sum;
  logic [SB:0]      q;

  // floor(smp * g / 2^32), g in Q0.32 up to 1.0
  assign smp  = (state_r == B_LEFT) ? left_r : right_r;
  assign neg  = smp[SB-1];
  assign mag  = neg ? (SB'(0) - smp) : smp;
  assign prod = (SB+32)'(mag) * (SB+32)'(g_r[31:0]);
  assign sum  = (SB+33)'(prod) + (neg ? (SB+33)'(32'hFFFF_FFFF) : '0);
  assign q    = sum[SB+32:32];
  assign res  = g_r[GW-1] ? smp : (neg ? SB'((SB+1)'(0) - q) : SB'(q));

  assign load = (state_r == B_LOAD) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          state_nxt = B_LEFT;
        end
      end
      B_LEFT:  state_nxt = B_RIGHT;
      B_RIGHT: state_nxt = B_LOAD;
      B_LOAD: begin
        if (load) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      left_r  <= q_data[SB-1:0];
      right_r <= q_data[2*SB-1:SB];
      last_r  <= q_data[2*SB];
      g_r     <= q_data[2*SB+1 +: GW];
    end
    if (state_r == B_LEFT) begin
      lres_r <= res;
    end
    if (state_r == B_RIGHT) begin
      rres_r <= res;
    end
    if (load) begin
      out_left_r  <= lres_r;
      out_right_r <= rres_r;
      out_last_r  <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_left  = out_left_r;
  assign out_right = out_right_r;
  assign out_last  = out_last_r;

endmodule
